// File: sv/leb_pkg.sv
// Shared types and constants for the LEB128 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;

   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned HIGH_BITS  = 13;
   localparam int unsigned WIDE_BITS  = WORD_BITS + HIGH_BITS;
   localparam int unsigned SHIFT_BITS = 7;
   localparam int unsigned GROUP_BITS = 7;
   localparam int unsigned USED_BITS  = 16;

   localparam logic [SHIFT_BITS-1:0] SHIFT_MAX   = 7'd127;
   localparam logic [SHIFT_BITS-1:0] SHIFT_LIMIT = 7'd64;
   localparam logic [SHIFT_BITS:0]   GROUP_STEP  = 8'd7;

   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] BYTE_ALL_ONES = 8'h7f;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] decoded_value;
      logic [1:0]           status;
      logic [USED_BITS-1:0] bytes_consumed;
   } rsp_type;

   // Accumulated value and framing state carried from byte to byte.
   typedef struct packed {
      logic [WORD_BITS-1:0]  low_acc;
      logic [HIGH_BITS-1:0]  high_acc;
      logic [SHIFT_BITS-1:0] shift;
      logic                  skip_rest;
   } acc_type;

endpackage

`default_nettype wire

// File: sv/leb_decode_step.sv
// Per-byte decode step: next accumulator state and the result, if any.
`timescale 1ns / 1ps
`default_nettype none

module leb_decode_step #(
   parameter int unsigned COUNT_BITS = leb_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                      signed_mode,
   input  leb_pkg::req_type         req,
   input  leb_pkg::acc_type         acc_cur,
   input  wire  [COUNT_BITS-1:0]    count_cur,
   output leb_pkg::acc_type         acc_next,
   output logic [COUNT_BITS-1:0]    count_next,
   output logic                     emit,
   output leb_pkg::rsp_type         rsp
);

   logic [leb_pkg::GROUP_BITS-1:0] chunk;
   logic                           cont;
   logic                           last;
   logic [leb_pkg::SHIFT_BITS-1:0] sh;
   logic [leb_pkg::WIDE_BITS-1:0]  shifted;
   logic [leb_pkg::WIDE_BITS-1:0]  wide_acc;
   logic [leb_pkg::WIDE_BITS-1:0]  wide_ext;
   logic [leb_pkg::WIDE_BITS-1:0]  ext_mask;
   logic [leb_pkg::SHIFT_BITS:0]   sh_sum;
   logic [leb_pkg::SHIFT_BITS-1:0] sh_new;
   logic [COUNT_BITS-1:0]          count_inc;
   logic                           high_shift;
   logic                           uns_ovf;
   logic                           sgn_ovf;
   logic                           early_ovf;
   logic                           neg;
   logic                           fits;

   always_comb begin
      chunk      = req.data_byte[leb_pkg::GROUP_BITS-1:0];
      cont       = req.data_byte[7];
      last       = req.buffer_end;
      sh         = acc_cur.shift;
      high_shift = (sh >= leb_pkg::SHIFT_LIMIT);

      // Group placed at the current position; anything at or past the top drops out.
      shifted = {{(leb_pkg::WIDE_BITS - leb_pkg::GROUP_BITS){1'b0}}, chunk} << sh;

      uns_ovf = high_shift ? (chunk != '0)
                           : (shifted[leb_pkg::WIDE_BITS-1:leb_pkg::WORD_BITS] != '0);
      sgn_ovf = high_shift && (req.data_byte != leb_pkg::BYTE_ZERO)
                && (req.data_byte != leb_pkg::BYTE_ALL_ONES);
      early_ovf = signed_mode ? sgn_ovf : uns_ovf;

      if (signed_mode) begin
         wide_acc = {acc_cur.high_acc, acc_cur.low_acc} | shifted;
      end else begin
         wide_acc = {acc_cur.high_acc,
                     acc_cur.low_acc | shifted[leb_pkg::WORD_BITS-1:0]};
      end

      sh_sum = {1'b0, sh} + leb_pkg::GROUP_STEP;
      sh_new = sh_sum[leb_pkg::SHIFT_BITS] ? leb_pkg::SHIFT_MAX
                                           : sh_sum[leb_pkg::SHIFT_BITS-1:0];

      // Sign-extend from the new position when the final group is negative.
      neg      = req.data_byte[6];
      ext_mask = (signed_mode && neg) ? ({leb_pkg::WIDE_BITS{1'b1}} << sh_new) : '0;
      wide_ext = wide_acc | ext_mask;
      fits     = (wide_ext[leb_pkg::WORD_BITS-1] == neg)
                 && (wide_ext[leb_pkg::WIDE_BITS-1:leb_pkg::WORD_BITS]
                     == (neg ? {leb_pkg::HIGH_BITS{1'b1}} : {leb_pkg::HIGH_BITS{1'b0}}));

      count_inc = (count_cur == '1) ? count_cur : count_cur + 1'b1;

      emit               = 1'b0;
      rsp.decoded_value  = '0;
      rsp.status         = leb_pkg::STATUS_OK;
      rsp.bytes_consumed = leb_pkg::USED_BITS'(count_inc);

      if (early_ovf) begin
         emit       = 1'b1;
         rsp.status = leb_pkg::STATUS_OVERFLOW;
      end else if (!cont) begin
         emit = 1'b1;
         if (signed_mode && !fits) begin
            rsp.status = leb_pkg::STATUS_OVERFLOW;
         end else begin
            rsp.decoded_value = wide_ext[leb_pkg::WORD_BITS-1:0];
         end
      end else if (last) begin
         emit       = 1'b1;
         rsp.status = leb_pkg::STATUS_TRUNCATED;
      end

      if (acc_cur.skip_rest) begin
         // Drop bytes until the buffer ends.
         emit               = 1'b0;
         acc_next           = acc_cur;
         acc_next.skip_rest = !last;
         count_next         = count_cur;
      end else if (emit) begin
         acc_next.low_acc   = '0;
         acc_next.high_acc  = '0;
         acc_next.shift     = '0;
         acc_next.skip_rest = !last;
         count_next         = '0;
      end else begin
         acc_next.low_acc   = wide_acc[leb_pkg::WORD_BITS-1:0];
         acc_next.high_acc  = wide_acc[leb_pkg::WIDE_BITS-1:leb_pkg::WORD_BITS];
         acc_next.shift     = sh_new;
         acc_next.skip_rest = 1'b0;
         count_next         = count_inc;
      end
   end

endmodule

`default_nettype wire

// File: sv/leb128_stream_decoder_unit.sv
// Top level of the LEB128 stream decoder: input register, decode step, result register.
//
//   channel  direction  handshake                     payload
//   req      in         req_valid / req_ready         req_data (leb_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready         rsp_data (leb_pkg::rsp_type)
//   csr      in         csr_write_enable              csr_write_data (signed_mode)
//
// One byte per cycle while the result register is free or rsp_ready is high: a byte is held
// in the input register and decoded as it moves on, so rsp_valid rises when its final byte leaves it.
// The accumulator update (77-bit shift, OR, range compare) sets the cycle time.
// Synchronous reset clears the decode state and the mode register.
// A result held in the output register stalls the decode step until rsp_ready is high;
// bytes keep flowing while rsp_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module leb128_stream_decoder_unit #(
   parameter int unsigned COUNT_BITS = leb_pkg::COUNT_BITS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  leb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output leb_pkg::rsp_type  rsp_data,
   input  wire               csr_write_enable,
   input  wire               csr_write_data
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   leb_pkg::req_type      in_data_ff;
   logic                  mode_ff;
   leb_pkg::acc_type      acc_ff;
   leb_pkg::acc_type      acc_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   leb_pkg::rsp_type      rsp_data_ff;
   leb_pkg::rsp_type      step_rsp;
   logic                  step_emit;
   logic                  advance;

   leb_decode_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .signed_mode (mode_ff),
      .req         (in_data_ff),
      .acc_cur     (acc_ff),
      .count_cur   (count_ff),
      .acc_next    (acc_in),
      .count_next  (count_in),
      .emit        (step_emit),
      .rsp         (step_rsp)
   );

   always_comb begin
      // Decode the held byte once the output register can take its result.
      advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;

      in_valid_in = req_ready ? req_valid : in_valid_ff;

      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (advance) begin
            acc_ff   <= acc_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: test/leb128_stream_decoder_unit_tb.sv
// Self-checking testbench for the LEB128 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module leb128_stream_decoder_unit_tb;

   localparam logic MODE_UNSIGNED = 1'b0;
   localparam logic MODE_SIGNED   = 1'b1;

   localparam logic [7:0] CONT_BIT = 8'h80;
   localparam logic [leb_pkg::USED_BITS-1:0] COUNT_MAX =
      leb_pkg::USED_BITS'((1 << leb_pkg::COUNT_BITS_DEFAULT) - 1);

   localparam int GAP_CAP      = 24;
   localparam int DRAIN_CYCLES = 4;
   localparam int HANG_LIMIT   = 2000;
   localparam int PHASE_ITEMS  = 200;

   localparam int SEND_IDLE_PCT [4] = '{0, 52, 0, 15};
   localparam int RSP_STALL_PCT [4] = '{0, 0, 52, 15};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   leb_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   leb_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic             csr_write_data = 1'b0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit failed = 1'b0;

   // Predicted decoder state
   logic [leb_pkg::WIDE_BITS-1:0]  acc_wide = '0;
   logic [leb_pkg::SHIFT_BITS-1:0] acc_shift = '0;
   logic [leb_pkg::USED_BITS-1:0]  byte_count = '0;
   bit                             skipping = 1'b0;
   logic                           mode_q = MODE_UNSIGNED;
   leb_pkg::rsp_type               pending_decodes[$];

   leb128_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic void close_value(logic [leb_pkg::WORD_BITS-1:0] value,
                                       logic [1:0] status, bit last);
      leb_pkg::rsp_type r;
      r.decoded_value  = value;
      r.status         = status;
      r.bytes_consumed = byte_count;
      pending_decodes.push_back(r);
      acc_wide   = '0;
      acc_shift  = '0;
      byte_count = '0;
      skipping   = !last;
   endfunction

   function automatic void decode_byte(logic [7:0] b, bit last);
      logic [leb_pkg::WIDE_BITS-1:0] placed;
      logic [leb_pkg::HIGH_BITS:0]   top;
      int                            next_shift;
      bit                            neg;
      if (skipping) begin
         if (last)
            skipping = 1'b0;
         return;
      end
      if (byte_count != COUNT_MAX)
         byte_count = byte_count + 1'b1;

      placed = '0;
      placed[leb_pkg::GROUP_BITS-1:0] = b[leb_pkg::GROUP_BITS-1:0];
      placed = placed << acc_shift;
      if (mode_q == MODE_UNSIGNED) begin
         if ((acc_shift >= leb_pkg::SHIFT_LIMIT)
             ? (b[leb_pkg::GROUP_BITS-1:0] != '0)
             : (placed[leb_pkg::WIDE_BITS-1:leb_pkg::WORD_BITS] != '0)) begin
            close_value('0, leb_pkg::STATUS_OVERFLOW, last);
            return;
         end
         acc_wide[leb_pkg::WORD_BITS-1:0] = acc_wide[leb_pkg::WORD_BITS-1:0]
                                            | placed[leb_pkg::WORD_BITS-1:0];
      end else begin
         if (acc_shift >= leb_pkg::SHIFT_LIMIT && b != leb_pkg::BYTE_ZERO
             && b != leb_pkg::BYTE_ALL_ONES) begin
            close_value('0, leb_pkg::STATUS_OVERFLOW, last);
            return;
         end
         acc_wide = acc_wide | placed;
      end

      next_shift = int'(acc_shift) + int'(leb_pkg::GROUP_STEP);
      acc_shift = (next_shift > int'(leb_pkg::SHIFT_MAX)) ? leb_pkg::SHIFT_MAX
                                                         : leb_pkg::SHIFT_BITS'(next_shift);

      if (!b[7]) begin
         if (mode_q == MODE_SIGNED) begin
            neg = b[6];
            if (neg)
               acc_wide = acc_wide | ({leb_pkg::WIDE_BITS{1'b1}} << acc_shift);
            // bits 63 and up must all match the sign
            top = acc_wide[leb_pkg::WIDE_BITS-1:leb_pkg::WORD_BITS-1];
            if (neg ? (top != '1) : (top != '0)) begin
               close_value('0, leb_pkg::STATUS_OVERFLOW, last);
               return;
            end
         end
         close_value(acc_wide[leb_pkg::WORD_BITS-1:0], leb_pkg::STATUS_OK, last);
         return;
      end
      if (last)
         close_value('0, leb_pkg::STATUS_TRUNCATED, 1'b1);
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit last);
      int gap;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, last};
      do @(posedge clock); while (!req_ready);
      decode_byte(b, last);
      items_sent++;
   endtask

   // Drop valid, let every expected result arrive and the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic mode);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      mode_q = mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic int value_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return $urandom_range(1, 3);
      if (r < 85)
         return $urandom_range(4, 10);
      return $urandom_range(11, 22);
   endfunction

   // Keep top groups near the range boundary; tame groups from bit 70 are 0 or 7f.
   function automatic logic [6:0] value_group(int pos, int len, bit tame);
      int r;
      r = $urandom_range(0, 3);
      if (tame && pos >= 10)
         return (pos == len - 1 && r[0]) ? leb_pkg::BYTE_ALL_ONES[6:0]
                                         : leb_pkg::BYTE_ZERO[6:0];
      if (pos >= 9) begin
         case (r)
            0: return leb_pkg::BYTE_ZERO[6:0];
            1: return leb_pkg::BYTE_ALL_ONES[6:0];
            2: return 7'd1;
            default: return 7'($urandom);
         endcase
      end
      if (r == 0)
         return $urandom_range(0, 1) ? leb_pkg::BYTE_ALL_ONES[6:0] : leb_pkg::BYTE_ZERO[6:0];
      return 7'($urandom);
   endfunction

   task automatic send_random_buffer();
      int  pick, len, cut, junk, i;
      bit  tame;
      pick = $urandom_range(0, 99);
      len  = value_length();
      tame = $urandom_range(0, 1);
      if (pick < 10) begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
      end else if (pick < 20) begin
         // end the buffer while the value still continues
         cut = $urandom_range(1, len);
         for (i = 0; i < cut; i++)
            send_byte({1'b1, value_group(i, len, tame)}, i == cut - 1);
      end else begin
         junk = (pick < 35) ? $urandom_range(1, 4) : 0;
         for (i = 0; i < len; i++)
            send_byte({(i != len - 1), value_group(i, len, tame)}, junk == 0 && i == len - 1);
         for (i = 0; i < junk; i++)
            send_byte(8'($urandom), i == junk - 1);
      end
   endtask

   task automatic test_unsigned_directed();
      set_mode(MODE_UNSIGNED);
      send_byte(leb_pkg::BYTE_ZERO, 1'b1);
      repeat (9) send_byte(8'hff, 1'b0);
      send_byte(8'h01, 1'b1);
      repeat (9) send_byte(CONT_BIT, 1'b0);
      send_byte(8'h02, 1'b1);
      send_byte(CONT_BIT, 1'b1);
      send_byte(8'h05, 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(8'hbb, 1'b1);
   endtask

   task automatic test_signed_directed();
      set_mode(MODE_SIGNED);
      send_byte(leb_pkg::BYTE_ALL_ONES, 1'b1);
      send_byte(8'h40, 1'b1);
      send_byte(8'h3f, 1'b1);
   endtask

   task automatic test_mode_switch_mid_value();
      set_mode(MODE_UNSIGNED);
      send_byte(8'h81, 1'b0);
      set_mode(MODE_SIGNED);
      send_byte(leb_pkg::BYTE_ALL_ONES, 1'b1);
   endtask

   task automatic test_random_phase(input int phase);
      int half, target;
      send_idle_pct = SEND_IDLE_PCT[phase];
      rsp_stall_pct = RSP_STALL_PCT[phase];
      for (half = 0; half < 2; half++) begin
         set_mode(logic'(half ^ (phase & 1)));
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target)
            send_random_buffer();
      end
   endtask

   always @(posedge clock) begin : check_result
      leb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decodes.size() == 0) begin
            $display("%0t: unexpected transaction, got value %h status %0d count %0d",
                     $time, rsp_data.decoded_value, rsp_data.status, rsp_data.bytes_consumed);
            failed = 1'b1;
         end else begin
            want = pending_decodes.pop_front();
            if (rsp_data.decoded_value !== want.decoded_value) begin
               $display("%0t: decoded_value expected %h, got %h",
                        $time, want.decoded_value, rsp_data.decoded_value);
               failed = 1'b1;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               failed = 1'b1;
            end
            if (rsp_data.bytes_consumed !== want.bytes_consumed) begin
               $display("%0t: bytes_consumed expected %0d, got %0d",
                        $time, want.bytes_consumed, rsp_data.bytes_consumed);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("leb128_stream_decoder_unit_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unsigned_directed();
      test_signed_directed();
      test_mode_switch_mid_value();
      for (phase = 0; phase < 4; phase++)
         test_random_phase(phase);

      settle();
      if (!failed) begin
         $display("leb128_stream_decoder_unit_tb: PASS");
      end else begin
         $display("leb128_stream_decoder_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
